// ----- hdl/llst_pkg.sv -----
// package: sizes, codes and entry type of the least-loaded server table
`timescale 1ns / 1ps
package llst_pkg;
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [15:0] MAX_AGE_RST = 16'd10;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_AGE   = 2'd1;
	localparam logic [1:0] OP_FIND  = 2'd2;
	localparam logic [1:0] OP_LEAST = 2'd3;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_MISS = 2'd1;
	localparam logic [1:0] STS_FULL = 2'd2;

	typedef struct packed {
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [31:0] stamp;
		logic [31:0] load;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;
endpackage

// ----- hdl/least_loaded_server_table_top.sv -----
// top level: server table with add, age-out, find and least-busy operations
//
// usage: one input word per operation on the in channel (in_valid/in_stall),
// one result word per operation on the out channel (out_valid/out_stall).
// max_age is to be written by the user on the cfg channel
// (cfg_valid/cfg_ready) only while idle; the block does not enforce this.
// entries live in one synchronous memory read one entry per cycle; every
// operation scans the valid entries in order, and the next word is taken
// in the cycle after the result is registered. age-out writes kept entries
// back, packed to the front in order, during the scan; add does at most one
// write, after the scan.
// reset empties the table (count to zero) and sets max_age to 10; no
// clearing pass is needed. a stalled result is held in the output register;
// the next word may be accepted meanwhile, but its result waits until the
// held one is taken.
`timescale 1ns / 1ps
module least_loaded_server_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] max_age,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [63:0] address_high,
	input  logic [63:0] address_low,
	input  logic [31:0] report_time,
	input  logic [31:0] report_load,
	input  logic [31:0] current_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        removed_any,
	output logic [63:0] found_address_high,
	output logic [63:0] found_address_low,
	output logic [31:0] found_time,
	output logic [31:0] found_load
);
	import llst_pkg::*;

	entry_t mem [TABLE_ENTRIES];

	state_t           state_q;
	logic [15:0]      max_age_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] kept_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rd_data_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t           sel_q;

	logic [1:0]       op_q;
	logic [63:0]      addr_high_q;
	logic [63:0]      addr_low_q;
	logic [31:0]      rtime_q;
	logic [31:0]      rload_q;
	logic [31:0]      now_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic             removed_q;
	entry_t           found_q;

	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	entry_t           wr_data;
	logic             rd_issue;
	logic             match;
	logic             stale;
	logic             out_free;
	logic             table_full;
	entry_t           new_entry;
	logic [1:0]       res_status;
	logic             res_removed;
	entry_t           res_found;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign rd_issue  = (state_q == ST_SCAN) && (rd_ptr_q < count_q);
	assign match     = (rd_data_s1.addr_high == addr_high_q) &&
	                   (rd_data_s1.addr_low == addr_low_q);
	assign stale     = ({1'b0, rd_data_s1.stamp} + {17'd0, max_age_q}) < {1'b0, now_q};
	assign table_full = (count_q == CNT_W'(TABLE_ENTRIES));
	assign new_entry = '{addr_high: addr_high_q, addr_low: addr_low_q,
	                     stamp: rtime_q, load: rload_q};

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = '0;
		wr_data = rd_data_s1;
		if (state_q == ST_SCAN && rd_vld_s1 && op_q == OP_AGE && !stale) begin
			wr_en  = 1'b1;
			wr_idx = kept_q[IDX_W-1:0];
		end else if (state_q == ST_FIN && out_free && op_q == OP_ADD) begin
			wr_data = new_entry;
			if (hit_q) begin
				wr_en  = 1'b1;
				wr_idx = hit_idx_q;
			end else if (!table_full) begin
				wr_en  = 1'b1;
				wr_idx = count_q[IDX_W-1:0];
			end
		end
	end

	// result word of the finished operation
	always_comb begin
		res_status  = STS_OK;
		res_removed = 1'b0;
		res_found   = '0;
		case (op_q)
			OP_ADD: begin
				if (!hit_q && table_full) begin
					res_status = STS_FULL;
				end
			end
			OP_AGE: begin
				res_removed = (kept_q != count_q);
			end
			OP_FIND, OP_LEAST: begin
				if (hit_q) begin
					res_found = sel_q;
				end else begin
					res_status = STS_MISS;
				end
			end
			default: begin
				res_status = STS_OK;
			end
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[rd_ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= MAX_AGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_age_q <= max_age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			kept_q      <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= rd_issue;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q  <= ST_SCAN;
						rd_ptr_q <= '0;
						kept_q   <= '0;
						hit_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_issue) begin
						rd_ptr_q <= rd_ptr_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						case (op_q)
							OP_ADD, OP_FIND: begin
								if (match && !hit_q) begin
									hit_q <= 1'b1;
								end
							end
							OP_AGE: begin
								if (!stale) begin
									kept_q <= kept_q + CNT_W'(1);
								end
							end
							default: begin
								hit_q <= 1'b1;
							end
						endcase
					end
					if (!rd_issue && !rd_vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (op_q == OP_AGE) begin
							count_q <= kept_q;
						end else if (op_q == OP_ADD && !hit_q && !table_full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item, scan and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q        <= operation;
			addr_high_q <= address_high;
			addr_low_q  <= address_low;
			rtime_q     <= report_time;
			rload_q     <= report_load;
			now_q       <= current_time;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if ((op_q inside {OP_ADD, OP_FIND}) && match && !hit_q) begin
				hit_idx_q <= idx_s1;
				sel_q     <= rd_data_s1;
			end else if (op_q == OP_LEAST && (!hit_q || rd_data_s1.load < sel_q.load)) begin
				sel_q <= rd_data_s1;
			end
		end
		if (rd_issue) begin
			idx_s1 <= rd_ptr_q[IDX_W-1:0];
		end
		if (state_q == ST_FIN && out_free) begin
			status_q  <= res_status;
			removed_q <= res_removed;
			found_q   <= res_found;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign removed_any        = removed_q;
	assign found_address_high = found_q.addr_high;
	assign found_address_low  = found_q.addr_low;
	assign found_time         = found_q.stamp;
	assign found_load         = found_q.load;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ({1'b0, idx_s1} < count_q))
		else $error("read of an entry past the count");

	a_age_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free && op_q == OP_AGE) |=> count_q <= $past(count_q))
		else $error("age-out grew the table");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result registered outside the finish step");
endmodule

// ----- verif/llst_checker.sv -----
// checker: predicts the server table result words and compares each one
`timescale 1ns / 1ps
module llst_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] max_age,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [63:0] address_high,
	input  logic [63:0] address_low,
	input  logic [31:0] report_time,
	input  logic [31:0] report_load,
	input  logic [31:0] current_time,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic        removed_any,
	input  logic [63:0] found_address_high,
	input  logic [63:0] found_address_low,
	input  logic [31:0] found_time,
	input  logic [31:0] found_load,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	import llst_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic       removed;
		entry_t     found;
	} reply_t;

	entry_t      servers [TABLE_ENTRIES];
	int          server_count = 0;
	logic [15:0] age_limit = MAX_AGE_RST;
	reply_t      replies_due [$];
	int          mismatches = 0;
	int          words_seen = 0;
	int          due_now = 0;

	assign fail_count = mismatches;
	assign pending = due_now;
	assign checked = words_seen;

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("checker: result word %0d: %s", words_seen, what);
	endtask

	function automatic reply_t apply_word(input logic [1:0] op, input logic [63:0] hi,
		input logic [63:0] lo, input logic [31:0] rtime, input logic [31:0] rload,
		input logic [31:0] now);
		reply_t r;
		int     hit;
		int     kept;
		int     best;
		int     i;
		r = '0;
		hit = -1;
		for (i = 0; i < server_count; i++)
			if (hit < 0 && servers[i].addr_high == hi && servers[i].addr_low == lo)
				hit = i;
		case (op)
			OP_ADD: begin
				if (hit >= 0) begin
					servers[hit].stamp = rtime;
					servers[hit].load = rload;
				end else if (server_count < TABLE_ENTRIES) begin
					servers[server_count] = '{hi, lo, rtime, rload};
					server_count++;
				end else begin
					r.status = STS_FULL;
				end
			end
			OP_AGE: begin
				// stale when stamp + max_age < now, sum taken without wrap
				kept = 0;
				for (i = 0; i < server_count; i++)
					if ({1'b0, servers[i].stamp} + {17'd0, age_limit} >= {1'b0, now}) begin
						servers[kept] = servers[i];
						kept++;
					end
				r.removed = (kept != server_count);
				server_count = kept;
			end
			OP_FIND: begin
				if (hit >= 0)
					r.found = servers[hit];
				else
					r.status = STS_MISS;
			end
			default: begin
				if (server_count == 0) begin
					r.status = STS_MISS;
				end else begin
					best = 0;
					for (i = 1; i < server_count; i++)
						if (servers[i].load < servers[best].load)
							best = i;
					r.found = servers[best];
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			server_count = 0;
			age_limit = MAX_AGE_RST;
			replies_due.delete();
			due_now = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					flag_mismatch("result word with none expected");
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status)
						flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
					if (removed_any !== want.removed)
						flag_mismatch($sformatf("removed_any %0d, want %0d",
							removed_any, want.removed));
					if (found_address_high !== want.found.addr_high)
						flag_mismatch($sformatf("found_address_high %h, want %h",
							found_address_high, want.found.addr_high));
					if (found_address_low !== want.found.addr_low)
						flag_mismatch($sformatf("found_address_low %h, want %h",
							found_address_low, want.found.addr_low));
					if (found_time !== want.found.stamp)
						flag_mismatch($sformatf("found_time %h, want %h",
							found_time, want.found.stamp));
					if (found_load !== want.found.load)
						flag_mismatch($sformatf("found_load %h, want %h",
							found_load, want.found.load));
				end
				words_seen++;
			end
			if (cfg_valid && cfg_ready)
				age_limit = max_age;
			if (in_valid && !in_stall)
				replies_due = {replies_due, apply_word(operation, address_high,
					address_low, report_time, report_load, current_time)};
			due_now = replies_due.size();
		end
	end

	final begin
		if (replies_due.size() != 0)
			$display("checker: %0d result words never arrived", replies_due.size());
	end
endmodule

// ----- verif/tb_least_loaded_server_table_top.sv -----
// testbench top: stimulus and verdict for the least-loaded server table
`timescale 1ns / 1ps
module tb_least_loaded_server_table_top;
	import llst_pkg::*;

	localparam int POOL = 24;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_WORDS = 305;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] max_age = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_ADD;
	logic [63:0] address_high = '0;
	logic [63:0] address_low = '0;
	logic [31:0] report_time = '0;
	logic [31:0] report_load = '0;
	logic [31:0] current_time = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        removed_any;
	logic [63:0] found_address_high;
	logic [63:0] found_address_low;
	logic [31:0] found_time;
	logic [31:0] found_load;

	int fail_count;
	int pending;
	int checked;

	logic [63:0] pool_hi [POOL];
	logic [63:0] pool_lo [POOL];
	logic [31:0] clock_now = '0;
	logic [15:0] cur_age = MAX_AGE_RST;
	bit          no_idle = 1'b0;
	bit          hold_now = 1'b0;
	int          stall_left = 0;
	int          op_seen [4] = '{0, 0, 0, 0};
	int          settings_used = 0;

	least_loaded_server_table_top u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.max_age            (max_age),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.operation          (operation),
		.address_high       (address_high),
		.address_low        (address_low),
		.report_time        (report_time),
		.report_load        (report_load),
		.current_time       (current_time),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.removed_any        (removed_any),
		.found_address_high (found_address_high),
		.found_address_low  (found_address_low),
		.found_time         (found_time),
		.found_load         (found_load)
	);

	llst_checker u_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.max_age            (max_age),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.operation          (operation),
		.address_high       (address_high),
		.address_low        (address_low),
		.report_time        (report_time),
		.report_load        (report_load),
		.current_time       (current_time),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.removed_any        (removed_any),
		.found_address_high (found_address_high),
		.found_address_low  (found_address_low),
		.found_time         (found_time),
		.found_load         (found_load),
		.fail_count         (fail_count),
		.pending            (pending),
		.checked            (checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random stalls, plus one long hold on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_now) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_now = 1'b0;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!no_idle && $urandom_range(0, 99) < 25)
					stall_left = pick_gap() + 1;
			end
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [63:0] hi,
		input logic [63:0] lo, input logic [31:0] rt, input logic [31:0] rl,
		input logic [31:0] now);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		address_high <= hi;
		address_low <= lo;
		report_time <= rt;
		report_load <= rl;
		current_time <= now;
		do @(posedge clk); while (in_stall);
		op_seen[op]++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic write_max_age(input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		max_age <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_age = value;
		settings_used++;
	endtask

	task automatic send_random();
		logic [1:0]  op;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [31:0] rt;
		logic [31:0] rl;
		logic [31:0] now;
		int          r;
		int          k;
		r = $urandom_range(0, 99);
		if (r < 45)
			op = OP_ADD;
		else if (r < 70)
			op = OP_FIND;
		else if (r < 85)
			op = OP_LEAST;
		else
			op = OP_AGE;
		k = $urandom_range(0, POOL - 1);
		hi = pool_hi[k];
		lo = pool_lo[k];
		if ($urandom_range(0, 9) == 0) begin
			hi = {$urandom, $urandom};
			lo = {$urandom, $urandom};
		end
		r = $urandom_range(0, 99);
		if (r < 80)
			rt = clock_now - 32'($urandom_range(0, 40));
		else if (r < 90)
			rt = $urandom;
		else
			rt = (r < 95) ? 32'h0 : 32'hFFFF_FFFF;
		rl = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : $urandom;
		r = $urandom_range(0, 99);
		if (r < 50)
			now = clock_now + 32'(cur_age) + 32'($urandom_range(0, 40)) - 32'd20;
		else if (r < 70)
			now = clock_now + 32'($urandom_range(0, 10));
		else if (r < 90)
			now = $urandom;
		else
			now = 32'($urandom_range(0, cur_age));
		clock_now += 32'($urandom_range(0, 3));
		send_word(op, hi, lo, rt, rl, now);
	endtask

	task automatic run_phase(input logic [15:0] age, input bit long_hold);
		int i;
		write_max_age(age);
		r_start: begin
			case ($urandom_range(0, 2))
				0: clock_now = 32'($urandom_range(0, 100));
				1: clock_now = $urandom;
				default: clock_now = 32'hFFFF_FF00;
			endcase
		end
		for (i = 0; i < PHASE_WORDS; i++) begin
			no_idle = (i % 150) < 25;
			if (long_hold && i == PHASE_WORDS / 3)
				hold_now = 1'b1;
			if (i == PHASE_WORDS / 2)
				drain();
			send_random();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int k;
		for (k = 0; k < POOL; k++) begin
			pool_hi[k] = {$urandom, $urandom};
			pool_lo[k] = {$urandom, $urandom};
		end
		pool_hi[0] = '1;
		pool_lo[0] = '1;
		pool_hi[1] = '0;
		pool_lo[1] = '0;
		pool_hi[3] = pool_hi[2];

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, max_age still at its reset value
		send_word(OP_LEAST, pool_hi[2], pool_lo[2], 0, 0, 0);
		send_word(OP_AGE, pool_hi[2], pool_lo[2], 0, 0, 32'hFFFF_FFFF);
		send_word(OP_ADD, pool_hi[2], pool_lo[2], 32'd100, 32'hFFFF_FFFF, 0);
		send_word(OP_ADD, pool_hi[0], pool_lo[0], 32'hFFFF_FFFF, 32'd0, 0);
		send_word(OP_ADD, pool_hi[1], pool_lo[1], 32'd0, 32'd0, 0);
		send_word(OP_LEAST, 0, 0, 0, 0, 0);
		send_word(OP_FIND, pool_hi[1], pool_lo[1], 0, 0, 0);
		send_word(OP_ADD, pool_hi[2], pool_lo[2], 32'd105, 32'd5, 0);
		send_word(OP_FIND, pool_hi[2], pool_lo[2], 0, 0, 0);
		send_word(OP_AGE, 0, 0, 0, 0, 32'd110);
		send_word(OP_AGE, 0, 0, 0, 0, 32'd5);
		for (k = 3; k < 17; k++)
			send_word(OP_ADD, pool_hi[k], pool_lo[k], 32'(200 + k), $urandom, 0);
		send_word(OP_ADD, pool_hi[17], pool_lo[17], 32'd300, 32'd1, 0);
		send_word(OP_ADD, pool_hi[2], pool_lo[2], 32'd301, 32'd2, 0);
		send_word(OP_FIND, pool_hi[17], pool_lo[17], 0, 0, 0);
		send_word(OP_LEAST, 0, 0, 0, 0, 0);
		send_word(OP_AGE, 0, 0, 0, 0, 32'hFFFF_FFFF);

		run_phase(16'd0, 1'b0);
		run_phase(16'hFFFF, 1'b1);
		run_phase(16'd1, 1'b0);
		run_phase(16'($urandom_range(2, 200)), 1'b1);
		run_phase(16'd10, 1'b0);
		run_phase(16'($urandom), 1'b0);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (25) @(posedge clk);

		$display("tb: %0d words sent (add %0d, age-out %0d, find %0d, least-busy %0d)",
			op_seen[OP_ADD] + op_seen[OP_AGE] + op_seen[OP_FIND] + op_seen[OP_LEAST],
			op_seen[OP_ADD], op_seen[OP_AGE], op_seen[OP_FIND], op_seen[OP_LEAST]);
		$display("tb: %0d result words checked over %0d max_age settings, %0d mismatches",
			checked, settings_used, fail_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("tb: timeout with %0d result words outstanding", pending);
		$display("tb: failure");
		$finish;
	end
endmodule
